// ===== rtl/prvm_pkg.sv =====
// ============================================================================
// prvm_pkg
// Shared widths, constants and codes of the ramp-compare voltage measurement
// engine.
// ============================================================================
package prvm_pkg;

    // field and state widths
    localparam int LEVEL_W    = 16;
    localparam int VOLT_W     = 22;
    localparam int SUM_W      = 26;
    localparam int IDX_W      = 4;
    localparam int RES_W      = 20;
    localparam int OFFS_W     = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // measurement constants
    localparam int SAMPLES       = 5;
    localparam int BACKOFF_STEPS = 5;
    localparam int MEAN_DIV      = SAMPLES - 2;

    localparam logic [VOLT_W-1:0] V_MAX = {VOLT_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE_MV = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_MV     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_RES     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_RES     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POLARITY      = 3'd5;

    // configuration reset values
    localparam logic [LEVEL_W-1:0]       RST_MAX_LEVEL  = 16'd255;
    localparam logic [15:0]              RST_FULL_SCALE = 16'd3300;
    localparam logic signed [OFFS_W-1:0] RST_OFFSET     = 13'sd0;
    localparam logic [RES_W-1:0]         RST_UPPER_RES  = 20'd100000;
    localparam logic [RES_W-1:0]         RST_LOWER_RES  = 20'd100000;

    // measurement phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RISE = 2'd1;
    localparam logic [1:0] PH_FALL = 2'd2;

    // input command codes
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

endpackage

// ===== rtl/prvm_ifs.sv =====
// ============================================================================
// prvm channel interfaces
// Valid/ready channels of the measurement engine: sample input, result output
// and configuration writes.
// ============================================================================

// command and comparator beats
interface prvm_in_if import prvm_pkg::*; ();
    logic valid;
    logic ready;
    logic command;
    logic comparator;

    modport source (output valid, output command, output comparator, input ready);
    modport sink   (input valid, input command, input comparator, output ready);
endinterface

// result beats
interface prvm_out_if import prvm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] pwm_level;
    logic               done_res;
    logic               error;
    logic [VOLT_W-1:0]  voltage_mv;

    modport source (output valid, output pwm_level, output done_res, output error,
                    output voltage_mv, input ready);
    modport sink   (input valid, input pwm_level, input done_res, input error,
                    input voltage_mv, output ready);
endinterface

// configuration register writes
interface prvm_cfg_if import prvm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pwm_ramp_voltage_measure.sv =====
// ============================================================================
// pwm_ramp_voltage_measure
// Ramp-compare voltage measurement: steps the pwm level against a comparator,
// converts each trip level to millivolts and reports the trimmed mean.
// ============================================================================
//
//  channel  | dir | port  | payload
//  ---------+-----+-------+------------------------------------------------
//  sample   | in  | i_in  | command, comparator
//  result   | out | o_out | pwm_level, done_res, error, voltage_mv
//  config   | in  | i_cfg | index, data (always ready)
//
// A start or plain step beat goes from accept through the decide and commit
// states to the result register. A trip beat (level converted to mV) forms a
// 32-bit quotient on the shared restoring divider for the level scale and a
// 22-bit one for the divider ratio, each after the shared multiplier. The last
// beat of a measurement forms a 26-bit quotient for the trimmed mean.
// Synchronous active-low reset restores the register defaults and idle phase.
// A result waits in the output register while the next beat is accepted; the
// block only stalls at the hand-off if the previous result is still held.
// ============================================================================
module pwm_ramp_voltage_measure
    import prvm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    prvm_in_if.sink     i_in,
    prvm_out_if.source  o_out,
    prvm_cfg_if.sink    i_cfg
);

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECIDE = 4'd1;
    localparam logic [3:0] ST_MUL1   = 4'd2;
    localparam logic [3:0] ST_DIV1   = 4'd3;
    localparam logic [3:0] ST_OFFS   = 4'd4;
    localparam logic [3:0] ST_MUL2   = 4'd5;
    localparam logic [3:0] ST_CHECK  = 4'd6;
    localparam logic [3:0] ST_DIV2   = 4'd7;
    localparam logic [3:0] ST_MEAN   = 4'd8;
    localparam logic [3:0] ST_COMMIT = 4'd9;

    // configuration registers
    logic [LEVEL_W-1:0]       r_max_level;
    logic [15:0]              r_full_scale;
    logic signed [OFFS_W-1:0] r_offset;
    logic [RES_W-1:0]         r_upper;
    logic [RES_W-1:0]         r_lower;
    logic                     r_polarity;

    // measurement state
    logic [3:0]         r_state;
    logic [1:0]         r_phase;
    logic [LEVEL_W-1:0] r_level;
    logic [IDX_W-1:0]   r_idx;
    logic [SUM_W-1:0]   r_sum;
    logic [VOLT_W-1:0]  r_hi;
    logic [VOLT_W-1:0]  r_lo;

    // latched beat and datapath registers
    logic        r_cmd;
    logic        r_cmp;
    logic [21:0] r_vm;
    logic [42:0] r_prod;
    logic [19:0] r_rem;
    logic [31:0] r_quo;
    logic [19:0] r_dsr;
    logic [5:0]  r_cnt;

    // output register
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_level;
    logic               r_out_done;
    logic               r_out_err;
    logic [VOLT_W-1:0]  r_out_volt;

    // commit values
    logic [LEVEL_W-1:0] n_level;
    logic [1:0]         n_phase;
    logic [IDX_W-1:0]   n_idx;
    logic [SUM_W-1:0]   n_sum;
    logic [VOLT_W-1:0]  n_hi;
    logic [VOLT_W-1:0]  n_lo;
    logic               n_err;
    logic               n_done;
    logic [VOLT_W-1:0]  n_mean;

    logic               active;
    logic               out_free;
    logic [IDX_W-1:0]   idx_inc;
    logic               last_sample;
    logic [SUM_W-1:0]   trim_sum;
    logic [LEVEL_W-1:0] lvl_base;
    logic [20:0]        res_sum;
    logic [21:0]        mul_a;
    logic [20:0]        mul_b;
    logic [42:0]        mul_p;
    logic [20:0]        div_sh;
    logic [21:0]        div_diff;
    logic               div_ge;
    logic signed [33:0] v_signed;
    logic               v_pos;
    logic               v_big;
    logic [VOLT_W-1:0]  v_mv;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_out_valid;
    assign o_out.pwm_level  = r_out_level;
    assign o_out.done_res   = r_out_done;
    assign o_out.error      = r_out_err;
    assign o_out.voltage_mv = r_out_volt;

    assign out_free    = !r_out_valid || o_out.ready;
    assign active      = (r_cmp == r_polarity);
    assign idx_inc     = r_idx + IDX_W'(1);
    assign last_sample = (idx_inc >= IDX_W'(SAMPLES));
    assign trim_sum    = r_sum - {4'b0, r_hi} - {4'b0, r_lo};
    assign lvl_base    = r_level - LEVEL_W'(1);
    assign res_sum     = {1'b0, r_upper} + {1'b0, r_lower};

    // shared multiplier: level scale first, divider ratio second
    always_comb begin
        if (r_state == ST_MUL2) begin
            mul_a = r_vm;
            mul_b = res_sum;
        end else begin
            mul_a = {6'b0, r_full_scale};
            mul_b = {5'b0, lvl_base};
        end
        mul_p = {21'b0, mul_a} * {22'b0, mul_b};
    end

    // shared restoring divider step, one quotient bit per cycle
    assign div_sh   = {r_rem, r_quo[31]};
    assign div_diff = {1'b0, div_sh} - {2'b0, r_dsr};
    assign div_ge   = !div_diff[21];

    // scaled level minus comparator offset
    assign v_signed = $signed({2'b00, r_quo}) - 34'(r_offset);
    assign v_pos    = !v_signed[33] && (v_signed != 34'sd0);
    assign v_big    = (v_signed[32:22] != 11'd0);

    assign v_mv = r_quo[VOLT_W-1:0];

    // state update applied when the result is committed
    always_comb begin
        n_level = r_level;
        n_phase = r_phase;
        n_idx   = r_idx;
        n_sum   = r_sum;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_err   = 1'b0;
        n_done  = 1'b0;
        n_mean  = '0;
        if (r_cmd == CMD_START) begin
            n_idx   = '0;
            n_sum   = '0;
            n_hi    = '0;
            n_lo    = V_MAX;
            n_level = LEVEL_W'(1);
            n_phase = PH_RISE;
            n_err   = (r_max_level == '0);
        end else begin
            case (r_phase)
                PH_RISE: begin
                    if (active) begin
                        if (r_level == '0) begin
                            n_err = 1'b1;
                        end else begin
                            n_sum   = r_sum + {4'b0, v_mv};
                            n_hi    = (v_mv > r_hi) ? v_mv : r_hi;
                            n_lo    = (v_mv < r_lo) ? v_mv : r_lo;
                            n_level = r_level - LEVEL_W'(1);
                            n_phase = PH_FALL;
                        end
                    end else if (({1'b0, r_level} + 17'd1) > {1'b0, r_max_level}) begin
                        n_err = 1'b1;
                    end else begin
                        n_level = r_level + LEVEL_W'(1);
                    end
                end
                PH_FALL: begin
                    if (active) begin
                        if (r_level == '0) begin
                            n_err = 1'b1;
                        end else begin
                            n_level = r_level - LEVEL_W'(1);
                        end
                    end else begin
                        n_level = (r_level > LEVEL_W'(BACKOFF_STEPS)) ?
                                  r_level - LEVEL_W'(BACKOFF_STEPS) : '0;
                        n_idx   = idx_inc;
                        if (last_sample) begin
                            n_done  = 1'b1;
                            n_mean  = v_mv;
                            n_level = '0;
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_RISE;
                            n_err   = (n_level > r_max_level);
                        end
                    end
                end
                default: ;
            endcase
        end
        if (n_err) begin
            n_level = '0;
            n_phase = PH_IDLE;
        end
    end

    // control state, configuration and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_phase      <= PH_IDLE;
            r_level      <= '0;
            r_idx        <= '0;
            r_sum        <= '0;
            r_hi         <= '0;
            r_lo         <= V_MAX;
            r_out_valid  <= 1'b0;
            r_max_level  <= RST_MAX_LEVEL;
            r_full_scale <= RST_FULL_SCALE;
            r_offset     <= RST_OFFSET;
            r_upper      <= RST_UPPER_RES;
            r_lower      <= RST_LOWER_RES;
            r_polarity   <= 1'b0;
        end else begin
            // register writes
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_MAX_LEVEL:     r_max_level  <= i_cfg.data[LEVEL_W-1:0];
                    CFG_FULL_SCALE_MV: r_full_scale <= i_cfg.data[15:0];
                    CFG_OFFSET_MV:     r_offset     <= $signed(i_cfg.data[OFFS_W-1:0]);
                    CFG_UPPER_RES:     r_upper      <= i_cfg.data;
                    CFG_LOWER_RES:     r_lower      <= i_cfg.data;
                    CFG_POLARITY:      r_polarity   <= i_cfg.data[0];
                    default: ;
                endcase
            end

            // result register hand-off
            if (r_state == ST_COMMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            // sequencer
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (r_cmd == CMD_SAMPLE && r_phase == PH_RISE && active &&
                        r_level != '0) begin
                        r_state <= ST_MUL1;
                    end else if (r_cmd == CMD_SAMPLE && r_phase == PH_FALL &&
                                 !active && last_sample) begin
                        r_state <= ST_MEAN;
                    end else begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_MUL1: begin
                    r_state <= (r_max_level == '0) ? ST_OFFS : ST_DIV1;
                end
                ST_DIV1: begin
                    if (r_cnt == 6'd1) begin
                        r_state <= ST_OFFS;
                    end
                end
                ST_OFFS: begin
                    if (!v_pos || r_lower == '0 || v_big) begin
                        r_state <= ST_COMMIT;
                    end else begin
                        r_state <= ST_MUL2;
                    end
                end
                ST_MUL2: begin
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_state <= (r_prod[42:22] >= {1'b0, r_lower}) ? ST_COMMIT : ST_DIV2;
                end
                ST_DIV2, ST_MEAN: begin
                    if (r_cnt == 6'd1) begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                        r_phase <= n_phase;
                        r_level <= n_level;
                        r_idx   <= n_idx;
                        r_sum   <= n_sum;
                        r_hi    <= n_hi;
                        r_lo    <= n_lo;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath and result payload
    always_ff @(posedge i_clk) begin
        // latch the accepted beat
        if (r_state == ST_IDLE && i_in.valid) begin
            r_cmd <= i_in.command;
            r_cmp <= i_in.comparator;
        end

        // divider step in any divide state
        if (r_state == ST_DIV1 || r_state == ST_DIV2 || r_state == ST_MEAN) begin
            r_rem <= div_ge ? div_diff[19:0] : div_sh[19:0];
            r_quo <= {r_quo[30:0], div_ge};
            r_cnt <= r_cnt - 6'd1;
        end

        case (r_state)
            // trimmed sum over the constant divisor
            ST_DECIDE: begin
                r_rem <= '0;
                r_quo <= {trim_sum, 6'b0};
                r_dsr <= 20'(MEAN_DIV);
                r_cnt <= 6'd26;
            end
            // full scale times (level minus one), then divide by max level
            ST_MUL1: begin
                r_rem <= '0;
                r_quo <= (r_max_level == '0) ? 32'd0 : mul_p[31:0];
                r_dsr <= {4'b0, r_max_level};
                r_cnt <= 6'd32;
            end
            // clamp before the divider ratio
            ST_OFFS: begin
                if (!v_pos) begin
                    r_quo <= '0;
                end else if (r_lower == '0 || v_big) begin
                    r_quo <= {10'b0, V_MAX};
                end
                r_vm <= v_signed[21:0];
            end
            ST_MUL2: begin
                r_prod <= mul_p;
            end
            // quotient above 22 bits saturates, else divide with the high bits as remainder
            ST_CHECK: begin
                if (r_prod[42:22] >= {1'b0, r_lower}) begin
                    r_quo <= {10'b0, V_MAX};
                end else begin
                    r_rem <= r_prod[41:22];
                    r_quo <= {r_prod[21:0], 10'b0};
                    r_dsr <= r_lower;
                    r_cnt <= 6'd22;
                end
            end
            default: ;
        endcase

        // result payload
        if (r_state == ST_COMMIT && out_free) begin
            r_out_level <= n_level;
            r_out_done  <= n_done;
            r_out_err   <= n_err;
            r_out_volt  <= n_done ? n_mean : '0;
        end
    end

`ifndef SYNTHESIS
    // a result is never both done and aborted
    a_done_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.done_res && o_out.error))
        else $error("done and error both set");

    // a finished or aborted measurement parks the level at zero
    a_end_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.done_res || o_out.error)) |-> (o_out.pwm_level == '0))
        else $error("level not zero at end of measurement");

    // an accepted beat always moves the sequencer into decode
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == ST_DECIDE))
        else $error("accepted beat not decoded");

    // the phase only changes at commit
    a_phase_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_COMMIT) |=> $stable(r_phase))
        else $error("phase changed outside commit");
`endif

endmodule
